// ===== hw/rtl/rfq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfq_pkg
// Shared types and constants for the reversible FIFO queue.
// ----------------------------------------------------------------------------
package rfq_pkg;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 9;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_PEEK    = 2'd2,
    OP_REVERSE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } fsm_state_t;

  typedef struct packed {
    logic                 load;
    logic                 from_ram;
    status_t              status;
    logic [COUNT_W-1:0]   count;
  } rfq_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rfq_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfq_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rfq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfq_ctrl
// Ring pointer, item count and direction flag with the operation sequencer.
// ----------------------------------------------------------------------------
module rfq_ctrl
  import rfq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_fire,
  input  wire logic [1:0]                     operation,
  input  wire logic signed [DATA_W-1:0]       value,
  output logic                                busy,
  output logic                                ram_we,
  output logic      [$clog2(QUEUE_DEPTH)-1:0] ram_waddr,
  output logic      [DATA_W-1:0]              ram_wdata,
  output logic                                ram_re,
  output logic      [$clog2(QUEUE_DEPTH)-1:0] ram_raddr,
  output rfq_result_t                         result
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;

  fsm_state_t    state, state_next;
  logic [AW-1:0] front, front_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          flag, flag_next;

  op_t           op;
  logic          empty, full;
  logic [AW-1:0] back_pos, last_pos, head_pos;
  logic [AW-1:0] front_dec, front_inc;

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign op        = op_t'(operation);
  assign empty     = (cnt == '0);
  assign full      = (cnt == CW'(QUEUE_DEPTH));
  assign back_pos  = ring_add(front, cnt);
  assign last_pos  = ring_add(front, cnt - CW'(1));
  assign head_pos  = flag ? last_pos : front;
  assign front_dec = (front == '0) ? AW'(QUEUE_DEPTH - 1) : front - AW'(1);
  assign front_inc = (front == AW'(QUEUE_DEPTH - 1)) ? '0 : front + AW'(1);
  assign busy      = (state == S_READ);
  assign ram_wdata = $unsigned(value);
  assign ram_raddr = head_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      cnt   <= '0;
      flag  <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      cnt   <= cnt_next;
      flag  <= flag_next;
    end
  end

  always_comb begin
    state_next      = state;
    front_next      = front;
    cnt_next        = cnt;
    flag_next       = flag;
    ram_we          = 1'b0;
    ram_waddr       = back_pos;
    ram_re          = 1'b0;
    result.load     = 1'b0;
    result.from_ram = 1'b0;
    result.status   = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          result.load = 1'b1;
          unique case (op)
            OP_ENQUEUE: begin
              if (full) begin
                result.status = ST_FULL;
              end else begin
                ram_we   = 1'b1;
                cnt_next = cnt + CW'(1);
                if (flag) begin
                  ram_waddr  = front_dec;
                  front_next = front_dec;
                end
              end
            end
            OP_DEQUEUE: begin
              if (empty) begin
                result.status = ST_EMPTY;
              end else begin
                ram_re      = 1'b1;
                result.load = 1'b0;
                state_next  = S_READ;
                cnt_next    = cnt - CW'(1);
                if (!flag) begin
                  front_next = front_inc;
                end
              end
            end
            OP_PEEK: begin
              if (empty) begin
                result.status = ST_EMPTY;
              end else begin
                ram_re      = 1'b1;
                result.load = 1'b0;
                state_next  = S_READ;
              end
            end
            OP_REVERSE: begin
              flag_next = ~flag;
            end
          endcase
        end
      end
      S_READ: begin
        result.load     = 1'b1;
        result.from_ram = 1'b1;
        state_next      = S_IDLE;
      end
    endcase
    result.count = COUNT_W'(cnt_next);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/reversible_fifo_queue.sv =====
`default_nettype none
// Results: enqueue, reverse and failed reads give theirs in the cycle after the
// item is accepted; a successful dequeue or peek passes the slot RAM read register first.
// Intake: one item per cycle for non-reading operations while the output is taken;
// dequeue and peek hold off the next item until the slot RAM read has returned.
// Reset clears the front pointer, the count, the direction flag and the output
// valid flag; slot contents stay undefined, and no clearing pass runs.
// ----------------------------------------------------------------------------
// reversible_fifo_queue
// Bounded queue of signed words with enqueue, dequeue, peek and order reversal.
// ----------------------------------------------------------------------------
module reversible_fifo_queue
  import rfq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [1:0]               operation,
  input  wire logic signed [DATA_W-1:0] value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic      [1:0]               status,
  output logic signed [DATA_W-1:0]      read_data,
  output logic      [COUNT_W-1:0]       count
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic          busy;
  logic          in_fire;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  rfq_result_t   result;

  assign in_ready = !busy && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;

  rfq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .operation(operation),
    .value    (value),
    .busy     (busy),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .result   (result)
  );

  rfq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.load) begin
      status    <= result.status;
      count     <= result.count;
      read_data <= result.from_ram ? $signed(ram_rdata) : '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_read_completes: assert property (@(posedge clk) disable iff (rst)
    ram_re |=> (result.load && result.from_ram))
    else $error("A slot read was not followed by its result.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    result.load |-> !(out_valid && !out_ready))
    else $error("A result overwrote one that was not yet taken.");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |-> (read_data == '0 && count == '0))
    else $error("An empty read reported data or a nonzero count.");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (count == COUNT_W'(QUEUE_DEPTH)))
    else $error("A full enqueue reported a count below capacity.");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/rfq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfq_checker
// Watches both channels of the reversible queue. It keeps its own model of
// the ring, predicts the result of every accepted item and compares each
// accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module rfq_checker
  import rfq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire logic                     in_ready,
  input  wire logic [1:0]               operation,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire logic                     out_valid,
  input  wire logic                     out_ready,
  input  wire logic [1:0]               status,
  input  wire logic signed [DATA_W-1:0] read_data,
  input  wire logic [COUNT_W-1:0]       count,
  output int                            fail_count,
  output int                            outstanding
);

  localparam int SLOTS = 256;

  typedef struct {
    status_t            st;
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] cnt;
  } reply_t;

  logic [DATA_W-1:0]  ring_words [SLOTS];
  logic [7:0]         head_idx;
  logic [COUNT_W-1:0] held;
  logic               flipped;
  reply_t             replies_due [$];
  int                 mismatches = 0;

  assign fail_count = mismatches;

  function automatic reply_t queue_apply(op_t op, logic [DATA_W-1:0] word);
    reply_t     r;
    logic [7:0] pos;
    r.st   = ST_OK;
    r.data = '0;
    case (op) inside
      OP_ENQUEUE: begin
        if (held == SLOTS) begin
          r.st = ST_FULL;
        end else if (flipped) begin
          head_idx = head_idx - 8'd1;
          ring_words[head_idx] = word;
          held = held + 1'b1;
        end else begin
          pos = head_idx + held[7:0];
          ring_words[pos] = word;
          held = held + 1'b1;
        end
      end
      OP_DEQUEUE, OP_PEEK: begin
        if (held == 0) begin
          r.st = ST_EMPTY;
        end else begin
          pos = flipped ? head_idx + held[7:0] - 8'd1 : head_idx;
          r.data = ring_words[pos];
          if (op == OP_DEQUEUE) begin
            if (!flipped) head_idx = head_idx + 8'd1;
            held = held - 1'b1;
          end
        end
      end
      default: begin
        flipped = ~flipped;
      end
    endcase
    r.cnt = held;
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      head_idx = '0;
      held     = '0;
      flipped  = 1'b0;
      replies_due.delete();
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          $error("unexpected result: status %0d, read_data %0d, count %0d",
                 status, read_data, count);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0d, actual %0d", want.st, status);
            mismatches++;
          end
          if (read_data !== want.data) begin
            $error("read_data: expected %0d, actual %0d", $signed(want.data), read_data);
            mismatches++;
          end
          if (count !== want.cnt) begin
            $error("count: expected %0d, actual %0d", want.cnt, count);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        replies_due.push_back(queue_apply(op_t'(operation), value));
      end
      outstanding <= replies_due.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for the reversible queue. A short directed sequence covers the
// empty, single-item, wrap and reversed cases, then random traffic mixes,
// fills past capacity, then mostly dequeues, idling at random before that on
// both channels. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import rfq_pkg::*;

  localparam int  RANDOM_ITEMS = 400;
  localparam int  FILL_START   = 60;
  localparam int  DRAIN_START  = 340;
  localparam real RUN_LIMIT_NS = 3_000_000.0;

  typedef enum {MIX_OPS, FILL_UP, DRAIN_DOWN} traffic_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               operation;
  logic signed [DATA_W-1:0] value;
  logic                     out_valid;
  logic                     out_ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] read_data;
  logic [COUNT_W-1:0]       count;
  int                       fail_count;
  int                       outstanding;
  bit                       steady = 1'b0;

  op_t dir_ops [20] = '{
    OP_PEEK, OP_DEQUEUE, OP_REVERSE, OP_ENQUEUE, OP_REVERSE,
    OP_PEEK, OP_DEQUEUE, OP_ENQUEUE, OP_ENQUEUE, OP_ENQUEUE,
    OP_REVERSE, OP_PEEK, OP_ENQUEUE, OP_DEQUEUE, OP_REVERSE,
    OP_DEQUEUE, OP_DEQUEUE, OP_DEQUEUE, OP_DEQUEUE, OP_REVERSE
  };
  logic [DATA_W-1:0] dir_vals [20] = '{
    32'h5a5a_a5a5, 32'hffff_ffff, 32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000,
    32'h0000_0000, 32'hdead_beef, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
    32'h7fff_ffff, 32'h1111_1111, 32'h1234_5678, 32'h0000_0000, 32'hffff_ffff,
    32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000
  };

  reversible_fifo_queue dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .read_data (read_data),
    .count     (count)
  );

  rfq_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .read_data   (read_data),
    .count       (count),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic push_item(op_t op, logic [DATA_W-1:0] word);
    in_valid  <= 1'b1;
    operation <= op;
    value     <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic sender_gap();
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic wait_all_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic op_t pick_op(traffic_t mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      FILL_UP:    return op_t'(r < 96 ? OP_ENQUEUE : (r < 98 ? OP_PEEK : OP_REVERSE));
      DRAIN_DOWN: return op_t'(r < 10 ? OP_ENQUEUE : (r < 70 ? OP_DEQUEUE :
                         (r < 85 ? OP_PEEK : OP_REVERSE)));
      default:    return op_t'(r < 35 ? OP_ENQUEUE : (r < 65 ? OP_DEQUEUE :
                         (r < 80 ? OP_PEEK : OP_REVERSE)));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!steady && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("reversible_fifo_queue regression: fail");
    $finish;
  end

  initial begin
    traffic_t mode;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    operation <= OP_ENQUEUE;
    value     <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_ops[i]) begin
      push_item(dir_ops[i], dir_vals[i]);
      sender_gap();
    end
    wait_all_replies();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == FILL_START || i == DRAIN_START) wait_all_replies();
      steady = (i >= DRAIN_START);
      mode = i < FILL_START ? MIX_OPS : (i < DRAIN_START ? FILL_UP : DRAIN_DOWN);
      push_item(pick_op(mode), pick_word());
      sender_gap();
      if (!steady && $urandom_range(0, 49) == 0) wait_all_replies();
    end

    wait_all_replies();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("reversible_fifo_queue regression: pass");
    end else begin
      $display("reversible_fifo_queue regression: fail");
    end
    $finish;
  end

endmodule
